>>> src/csd_pkg.sv
// ----------------------------------------------------------------------------
// csd_pkg: shared definitions for the closed stroke detector
// Widths, register indexes and sequencer states used by the unit and checker.
// ----------------------------------------------------------------------------
package csd_pkg;

    localparam int COORD_BITS     = 16;
    localparam int SUM_BITS       = 32;
    localparam int CNT_BITS       = 8;
    localparam int THR_BITS       = 16;
    localparam int SQ_BITS        = 2 * COORD_BITS;
    localparam int RAD_BITS       = SQ_BITS + 1;
    localparam int ROOT_BITS      = COORD_BITS + 1;
    localparam int MUL_BITS       = THR_BITS + SUM_BITS;
    localparam int DIST_BITS      = 17;
    localparam int PATH_BITS      = 32;
    localparam int IN_TDATA_BITS  = 2 * COORD_BITS;
    localparam int OUT_FIELD_BITS = 1 + DIST_BITS + PATH_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int CFG_IDX_BITS   = 8;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CNT_BITS-1:0] MIN_POINTS_RST = CNT_BITS'(10);
    localparam logic [THR_BITS-1:0] RATIO_THR_RST  = THR_BITS'(9830);

    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_POINTS = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_RATIO_THR  = CFG_IDX_BITS'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SUMSQ,
        ST_ROOT,
        ST_ACCUM,
        ST_MUL,
        ST_DONE
    } t_state;

    typedef enum logic {
        PH_SEG,
        PH_END
    } t_phase;

endpackage

>>> src/closed_stroke_detector_unit.sv
// ----------------------------------------------------------------------------
// closed_stroke_detector_unit: closed shape detection on a point stream
// Accumulates stroke path length and checks end-to-start closure.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): one stroke point per word, x in tdata[15:0] and
//   y in tdata[31:16] (signed Q12.4), tlast marks the last point of a stroke.
//   Output stream (m_axis): one word per stroke, sent after its last point.
//   Config channel: write min_points (index 0) or ratio_threshold (index 1)
//   while the unit is idle; o_cfg_ready is always high.
// Sequence:
//   Each point except the first of a stroke runs one segment length: two
//   squarings on the shared multiplier, a sum, 17 restoring square root
//   steps and an accumulate, and no new point is taken until it is through.
//   A last point adds the end-to-start length, the threshold product and
//   the compare. The first point of a stroke goes straight back to idle, or
//   on to the product and compare when it is also the last. The square root
//   iteration is the longest step; tready is low while a point is in work.
// Reset and stall:
//   Reset (synchronous, active low) clears the stroke and loads
//   min_points = 10 and ratio_threshold = 9830. A finished word sits in the
//   output register while the next stroke keeps running; only a second
//   result waits in the compare step until the receiver takes the first.
module closed_stroke_detector_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // tdata fields from bit 0: point_x[15:0], point_y[31:16]
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [csd_pkg::IN_TDATA_BITS-1:0]    i_s_axis_tdata,
    input  logic                                 i_s_axis_tlast,
    // tdata fields from bit 0: is_closed[0], end_distance[17:1],
    // path_length[49:18], zero fill above
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [csd_pkg::OUT_TDATA_BITS-1:0]   o_m_axis_tdata,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [csd_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [csd_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);
    import csd_pkg::*;

    localparam logic [RAD_BITS-1:0] ROOT_START = RAD_BITS'(1) << (RAD_BITS - 1);

    // absolute difference of two signed coordinates fits the coordinate width
    function automatic logic [COORD_BITS-1:0] abs_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        logic [COORD_BITS:0] d;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        if (d[COORD_BITS]) begin
            d = -d;
        end
        return d[COORD_BITS-1:0];
    endfunction

    // sequencer and stroke state
    t_state                 r_state, n_state;
    t_phase                 r_phase;
    logic [CNT_BITS-1:0]    r_count;
    logic [SUM_BITS-1:0]    r_len_sum;
    logic [CNT_BITS-1:0]    r_min_points;
    logic [THR_BITS-1:0]    r_ratio_thr;
    logic                   r_out_valid;

    // payload registers
    logic [COORD_BITS-1:0]  r_x, r_y, r_first_x, r_first_y, r_prev_x, r_prev_y;
    logic                   r_last;
    logic [COORD_BITS-1:0]  r_dx, r_dy;
    logic [SQ_BITS-1:0]     r_sx, r_sy;
    logic [RAD_BITS-1:0]    r_rem, r_res, r_bit;
    logic [ROOT_BITS-1:0]   r_dist;
    logic [MUL_BITS-1:0]    r_prod;
    logic                   r_out_closed;
    logic [DIST_BITS-1:0]   r_out_dist;
    logic [PATH_BITS-1:0]   r_out_len;

    // decoded controls
    logic                   in_accept;
    logic                   out_load;
    logic [THR_BITS-1:0]    mul_a;
    logic [SUM_BITS-1:0]    mul_b;
    logic [MUL_BITS-1:0]    mul_p;

    // datapath helpers
    logic [COORD_BITS-1:0]  in_x, in_y;
    logic [RAD_BITS:0]      root_trial;
    logic                   root_take;
    logic [SUM_BITS:0]      sum_ext;
    logic [SUM_BITS-1:0]    sum_sat;
    logic [MUL_BITS-1:0]    dist_shift;
    logic                   closed;

    assign in_x = i_s_axis_tdata[COORD_BITS-1:0];
    assign in_y = i_s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign o_cfg_ready = 1'b1;

    // shared multiplier: squares of the differences, then the threshold product
    assign mul_p = MUL_BITS'(mul_a) * MUL_BITS'(mul_b);

    // one restoring square root step per cycle
    assign root_trial = {1'b0, r_rem} - ({1'b0, r_res} + {1'b0, r_bit});
    assign root_take  = ~root_trial[RAD_BITS];

    // saturating length accumulate
    assign sum_ext = {1'b0, r_len_sum} + (SUM_BITS + 1)'(r_res[ROOT_BITS-1:0]);
    assign sum_sat = sum_ext[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_ext[SUM_BITS-1:0];

    // closure test: a zero path length never passes
    assign dist_shift = MUL_BITS'(r_dist) << THR_BITS;
    assign closed = (r_count >= r_min_points) && (dist_shift < r_prod);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    if (r_count != '0) begin
                        n_state = ST_SQ_X;
                    end else if (i_s_axis_tlast) begin
                        n_state = ST_MUL;
                    end
                end
            end
            ST_SQ_X:  n_state = ST_SQ_Y;
            ST_SQ_Y:  n_state = ST_SUMSQ;
            ST_SUMSQ: n_state = ST_ROOT;
            ST_ROOT: begin
                if (r_bit[0]) begin
                    n_state = (r_phase == PH_SEG) ? ST_ACCUM : ST_MUL;
                end
            end
            ST_ACCUM: n_state = r_last ? ST_SQ_X : ST_IDLE;
            ST_MUL:   n_state = ST_DONE;
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_s_axis_tready = 1'b0;
        out_load        = 1'b0;
        mul_a           = r_dx;
        mul_b           = SUM_BITS'(r_dx);
        unique case (r_state)
            ST_IDLE: o_s_axis_tready = 1'b1;
            ST_SQ_X: begin
                mul_a = r_dx;
                mul_b = SUM_BITS'(r_dx);
            end
            ST_SQ_Y: begin
                mul_a = r_dy;
                mul_b = SUM_BITS'(r_dy);
            end
            ST_MUL: begin
                mul_a = r_ratio_thr;
                mul_b = r_len_sum;
            end
            ST_DONE:  out_load = ~r_out_valid | i_m_axis_tready;
            default: begin
            end
        endcase
    end

    assign in_accept = i_s_axis_tvalid & o_s_axis_tready;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_phase      <= PH_SEG;
            r_count      <= '0;
            r_len_sum    <= '0;
            r_min_points <= MIN_POINTS_RST;
            r_ratio_thr  <= RATIO_THR_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_MIN_POINTS: r_min_points <= i_cfg_data[CNT_BITS-1:0];
                    REG_RATIO_THR:  r_ratio_thr  <= i_cfg_data[THR_BITS-1:0];
                    default: begin
                    end
                endcase
            end
            if (r_state == ST_IDLE && in_accept) begin
                r_phase <= (r_count != '0) ? PH_SEG : PH_END;
                if (r_count == '0) begin
                    r_count <= CNT_BITS'(1);
                end
            end
            if (r_state == ST_ACCUM) begin
                r_len_sum <= sum_sat;
                r_phase   <= PH_END;
                if (r_count != {CNT_BITS{1'b1}}) begin
                    r_count <= r_count + CNT_BITS'(1);
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_count     <= '0;
                r_len_sum   <= '0;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && in_accept) begin
            r_x    <= in_x;
            r_y    <= in_y;
            r_last <= i_s_axis_tlast;
            r_dx   <= abs_diff(in_x, r_prev_x);
            r_dy   <= abs_diff(in_y, r_prev_y);
            r_res  <= '0;
            if (r_count == '0) begin
                r_first_x <= in_x;
                r_first_y <= in_y;
                r_prev_x  <= in_x;
                r_prev_y  <= in_y;
            end
        end
        if (r_state == ST_SQ_X) begin
            r_sx <= mul_p[SQ_BITS-1:0];
        end
        if (r_state == ST_SQ_Y) begin
            r_sy <= mul_p[SQ_BITS-1:0];
        end
        if (r_state == ST_SUMSQ) begin
            r_rem <= RAD_BITS'(r_sx) + RAD_BITS'(r_sy);
            r_res <= '0;
            r_bit <= ROOT_START;
        end
        if (r_state == ST_ROOT) begin
            if (root_take) begin
                r_rem <= root_trial[RAD_BITS-1:0];
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (r_state == ST_ACCUM) begin
            r_prev_x <= r_x;
            r_prev_y <= r_y;
            r_dx     <= abs_diff(r_x, r_first_x);
            r_dy     <= abs_diff(r_y, r_first_y);
        end
        if (r_state == ST_MUL) begin
            r_prod <= mul_p;
            r_dist <= r_res[ROOT_BITS-1:0];
        end
        if (out_load) begin
            r_out_closed <= closed;
            r_out_dist   <= DIST_BITS'(r_dist);
            r_out_len    <= PATH_BITS'(r_len_sum);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_TDATA_BITS - OUT_FIELD_BITS)'(0),
                              r_out_len, r_out_dist, r_out_closed};

endmodule

>>> src/csd_checker.sv
// ----------------------------------------------------------------------------
// csd_checker: port-level checks for the closed stroke detector
// Watches the output stream and the result word contents.
// ----------------------------------------------------------------------------
module csd_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_m_axis_tvalid,
    input logic                                 i_m_axis_tready,
    input logic [csd_pkg::OUT_TDATA_BITS-1:0]   o_m_axis_tdata
);
    import csd_pkg::*;

    logic [DIST_BITS-1:0] chk_dist;
    logic [PATH_BITS-1:0] chk_len;

    assign chk_dist = o_m_axis_tdata[DIST_BITS:1];
    assign chk_len  = o_m_axis_tdata[DIST_BITS+PATH_BITS:DIST_BITS+1];

    // hold a stalled word
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output word dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("output word changed while stalled");

    // a closed verdict needs a nonzero path
    a_closed_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[0] |-> chk_len != '0)
        else $error("closed stroke with zero path length");

    // ratio below one forces the gap below the path
    a_closed_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[0] |-> PATH_BITS'(chk_dist) < chk_len)
        else $error("closed stroke with end gap not below path length");

endmodule

bind closed_stroke_detector_unit csd_checker u_csd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

>>> tb/tb_closed_stroke_detector_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_closed_stroke_detector_unit: self-checking bench for the stroke detector
// Streams strokes of Q12.4 points through the unit under changing register
// settings and compares each closure word against an in-bench prediction.
// ----------------------------------------------------------------------------
module tb_closed_stroke_detector_unit;

    import csd_pkg::*;

    localparam int          CLK_HALF      = 5;
    localparam int          RESET_CYCLES  = 6;
    localparam int          SETTLE_CYCLES = 64;   // covers a last point still in work
    localparam int          DRAIN_CYCLES  = 100;
    localparam int          CYCLE_LIMIT   = 500000;
    localparam int          PHASE_POINTS  = 112;
    localparam int          NUM_PHASES    = 8;
    localparam logic [7:0]  MIN_PTS_INIT  = 8'd10;
    localparam logic [15:0] RATIO_INIT    = 16'd9830;
    localparam logic [63:0] SUM_LIMIT     = 64'hFFFF_FFFF;
    // index outside the register map: the write must leave both settings alone
    localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED = CFG_IDX_BITS'(8'hFE);

    // one closure verdict, as carried in the result word
    typedef struct packed {
        logic        closed;
        logic [16:0] end_dist;
        logic [31:0] path_len;
    } t_verdict;

    typedef enum int {
        SHAPE_LOOP,
        SHAPE_WALK,
        SHAPE_SCATTER,
        SHAPE_DOT
    } t_shape;

    // ------------------------------------------------------------------------
    // Closure tracker: mirrors the stroke state and the two settings, predicts
    // the verdict at every stroke end and checks the words that come back.
    // ------------------------------------------------------------------------
    class closure_tracker;
        logic [7:0]         min_pts;
        logic [15:0]        ratio_thr;
        logic signed [15:0] first_x, first_y, prev_x, prev_y;
        logic [7:0]         pt_count;
        logic [63:0]        len_sum;
        t_verdict           verdict_q[$];
        int                 mismatches;
        int                 verdicts_seen;
        int                 closed_seen;

        function new();
            min_pts       = MIN_PTS_INIT;
            ratio_thr     = RATIO_INIT;
            mismatches    = 0;
            verdicts_seen = 0;
            closed_seen   = 0;
            clear_stroke();
        endfunction

        function void clear_stroke();
            first_x  = '0;
            first_y  = '0;
            prev_x   = '0;
            prev_y   = '0;
            pt_count = '0;
            len_sum  = '0;
        endfunction

        function void set_config(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] data);
            if (idx == REG_MIN_POINTS)
                min_pts = data[7:0];
            else if (idx == REG_RATIO_THR)
                ratio_thr = data;
        endfunction

        // floor square root, digit by digit
        function logic [63:0] isqrt(logic [63:0] v);
            logic [63:0] rem, res, bitv;
            rem  = v;
            res  = '0;
            bitv = 64'd1 << 62;
            while (bitv > rem)
                bitv = bitv >> 2;
            while (bitv != 0) begin
                if (rem >= res + bitv) begin
                    rem = rem - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function logic [63:0] seg_len(logic signed [15:0] ax, logic signed [15:0] ay,
                                      logic signed [15:0] bx, logic signed [15:0] by);
            longint dx, dy;
            dx = longint'(ax) - longint'(bx);
            dy = longint'(ay) - longint'(by);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            return isqrt(64'(dx * dx + dy * dy));
        endfunction

        // advance the stroke by one accepted point; queue a verdict on its end
        function void note_point(logic signed [15:0] x, logic signed [15:0] y, logic last);
            logic [63:0] end_gap;
            t_verdict    v;
            if (pt_count == 0) begin
                first_x = x;
                first_y = y;
            end else begin
                len_sum = len_sum + seg_len(x, y, prev_x, prev_y);
                if (len_sum > SUM_LIMIT)
                    len_sum = SUM_LIMIT;
            end
            prev_x = x;
            prev_y = y;
            if (pt_count != 8'd255)
                pt_count = pt_count + 8'd1;
            if (!last)
                return;
            end_gap    = seg_len(x, y, first_x, first_y);
            v.closed   = (pt_count >= min_pts) &&
                         ((end_gap << 16) < (64'(ratio_thr) * len_sum));
            v.end_dist = end_gap[16:0];
            v.path_len = len_sum[31:0];
            verdict_q.push_back(v);
            clear_stroke();
        endfunction

        function void check_verdict(t_verdict got);
            t_verdict want;
            if (verdict_q.size() == 0) begin
                $error("result word with no stroke end pending: closed=%0d dist=%0d len=%0d",
                       got.closed, got.end_dist, got.path_len);
                mismatches++;
                return;
            end
            want = verdict_q.pop_front();
            verdicts_seen++;
            if (got.closed === 1'b1)
                closed_seen++;
            if (got.closed !== want.closed) begin
                $error("is_closed: expected %0d, got %0d", want.closed, got.closed);
                mismatches++;
            end
            if (got.end_dist !== want.end_dist) begin
                $error("end_distance: expected %0d, got %0d", want.end_dist, got.end_dist);
                mismatches++;
            end
            if (got.path_len !== want.path_len) begin
                $error("path_length: expected %0d, got %0d", want.path_len, got.path_len);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT signals and instance
    // ------------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                       i_s_axis_tvalid;
    logic                       o_s_axis_tready;
    logic [IN_TDATA_BITS-1:0]   i_s_axis_tdata;   // point_x[15:0], point_y[31:16]
    logic                       i_s_axis_tlast;   // stroke_end
    logic                       o_m_axis_tvalid;
    logic                       i_m_axis_tready = 1'b1;
    logic [OUT_TDATA_BITS-1:0]  o_m_axis_tdata;   // is_closed[0], end_distance[17:1],
                                                  // path_length[49:18]
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]    i_cfg_index;
    logic [CFG_DATA_BITS-1:0]   i_cfg_data;

    always #(CLK_HALF) i_clk = ~i_clk;

    closed_stroke_detector_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    closure_tracker     tracker;
    bit                 tx_idle;      // sender may insert gaps
    bit                 rx_idle;      // receiver may stall
    int                 stall_left;
    int                 cycle_count;
    int                 points_sent;
    int                 strokes_sent;
    int                 cfg_words;
    logic signed [15:0] path_x[$];
    logic signed [15:0] path_y[$];

    // ------------------------------------------------------------------------
    // Run watchdog: end the run with an error once the cycle limit is reached.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result sink: check every accepted word, then pick the next tready.
    // Stalls come in bursts of random length, started only while rx_idle is set.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_sink
        t_verdict got;
        if (i_rst_n === 1'b1 && o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
            got.closed   = o_m_axis_tdata[0];
            got.end_dist = o_m_axis_tdata[17:1];
            got.path_len = o_m_axis_tdata[49:18];
            tracker.check_verdict(got);
        end
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (rx_idle && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Point driver: present one word and hold it until the unit takes it.
    // A gap drops tvalid first so that it never falls and rises in one step.
    // ------------------------------------------------------------------------
    task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
                              input logic last);
        if (tx_idle && $urandom_range(0, 4) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {y, x};
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        tracker.note_point(x, y, last);
        points_sent++;
    endtask

    // send the staged path as one stroke, tlast on its final point
    task automatic flush_path();
        for (int i = 0; i < path_x.size(); i++)
            send_point(path_x[i], path_y[i], i == path_x.size() - 1);
        path_x.delete();
        path_y.delete();
        strokes_sent++;
    endtask

    // Stage a rectangular loop: q steps of size s along each side, ending back
    // at the start point moved by -jit/2 to jit - jit/2 in each axis.
    task automatic make_loop(input int cx, input int cy, input int q, input int s,
                             input int jit);
        int x, y;
        x = cx;
        y = cy;
        path_x.push_back(16'(x));
        path_y.push_back(16'(y));
        for (int side = 0; side < 4; side++) begin
            for (int k = 0; k < q; k++) begin
                case (side)
                    0: x = x + s;
                    1: y = y + s;
                    2: x = x - s;
                    default: y = y - s;
                endcase
                path_x.push_back(16'(x));
                path_y.push_back(16'(y));
            end
        end
        path_x[path_x.size() - 1] = 16'(cx + $urandom_range(0, jit) - jit / 2);
        path_y[path_y.size() - 1] = 16'(cy + $urandom_range(0, jit) - jit / 2);
    endtask

    // Stage one random stroke: half are loops with random size and closure
    // error, the rest open walks, scattered full-range points and dots.
    task automatic random_stroke();
        t_shape shape;
        int     pick, n, s, x, y, reach;
        pick  = $urandom_range(0, 99);
        shape = (pick < 50) ? SHAPE_LOOP : (pick < 75) ? SHAPE_WALK :
                (pick < 90) ? SHAPE_SCATTER : SHAPE_DOT;
        x = $urandom_range(0, 65535) - 32768;
        y = $urandom_range(0, 65535) - 32768;
        case (shape)
            SHAPE_LOOP: begin
                s = $urandom_range(1, 3000);
                make_loop(x, y, $urandom_range(1, 6), s,
                          ($urandom_range(0, 9) < 7) ? s / 4 : 4 * s);
            end
            SHAPE_WALK: begin
                n = $urandom_range(2, 30);
                case ($urandom_range(0, 2))
                    0: reach = 15;
                    1: reach = 255;
                    default: reach = 4095;
                endcase
                for (int i = 0; i < n; i++) begin
                    path_x.push_back(16'(x));
                    path_y.push_back(16'(y));
                    x = x + $urandom_range(0, 2 * reach) - reach;
                    y = y + $urandom_range(0, 2 * reach) - reach;
                end
            end
            SHAPE_SCATTER: begin
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++) begin
                    path_x.push_back(16'($urandom));
                    path_y.push_back(16'($urandom));
                end
            end
            default: begin
                // a dot, sometimes tapped several times in place
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) begin
                    path_x.push_back(16'(x));
                    path_y.push_back(16'(y));
                end
            end
        endcase
        flush_path();
    endtask

    // wait until every stroke end has been answered and the unit has settled
    task automatic wait_idle(input int settle);
        while (tracker.verdict_q.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Load both settings while idle; optionally poke the unmapped index too.
    // cfg_valid stays high across the burst and drops once after it.
    task automatic set_phase(input logic [7:0] mp, input logic [15:0] thr,
                             input bit poke_unmapped);
        logic [CFG_IDX_BITS-1:0] idx[3];
        logic [15:0]             data[3];
        int                      n;
        idx[0]  = REG_MIN_POINTS;
        data[0] = {8'($urandom), mp};   // upper byte must be ignored
        idx[1]  = REG_RATIO_THR;
        data[1] = thr;
        idx[2]  = REG_UNMAPPED;
        data[2] = 16'($urandom);
        n = poke_unmapped ? 3 : 2;
        // drop the point stream so the last point is not taken twice
        i_s_axis_tvalid <= 1'b0;
        wait_idle(SETTLE_CYCLES);
        for (int i = 0; i < n; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= data[i];
            do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
            tracker.set_config(idx[i], data[i]);
            cfg_words++;
        end
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [7:0]  phase_min[NUM_PHASES];
        logic [15:0] phase_thr[NUM_PHASES];
        int          phase_start;

        tracker      = new();
        cycle_count  = 0;
        stall_left   = 0;
        points_sent  = 0;
        strokes_sent = 0;
        cfg_words    = 0;
        tx_idle      = 1'b1;
        rx_idle      = 1'b1;

        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tlast  <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= '0;
        i_cfg_data      <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed strokes under the reset settings.
        // Single point at the coordinate extremes: zero distance, not closed.
        path_x.push_back(16'sh7FFF);
        path_y.push_back(-16'sh8000);
        flush_path();
        // Corner to corner: the largest segment and end distance.
        path_x.push_back(-16'sh8000);
        path_y.push_back(-16'sh8000);
        path_x.push_back(16'sh7FFF);
        path_y.push_back(16'sh7FFF);
        flush_path();
        // Tapped in place: zero path length keeps it open.
        for (int i = 0; i < 3; i++) begin
            path_x.push_back(16'sd100);
            path_y.push_back(-16'sd100);
        end
        flush_path();
        // Exact square of 13 points, back on the start: closed.
        make_loop(0, 0, 3, 160, 0);
        flush_path();

        // Random phases, each under its own settings; the extremes included.
        phase_min = '{8'd10, 8'd2,   8'd255, 8'd0,  8'd1,      8'd0, 8'd3,     8'd10};
        phase_thr = '{16'd9830, 16'hFFFF, 16'd9830, 16'd0, 16'h8000, 16'd0, 16'd20000,
                      16'd9830};
        phase_min[5] = 8'($urandom_range(2, 20));
        phase_thr[5] = 16'($urandom);

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == NUM_PHASES - 1) begin
                // last part runs with both sides at full rate
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end
            set_phase(phase_min[p], phase_thr[p], p == 6);
            phase_start = points_sent;
            if (p == 2) begin
                // 281 points: the count holds at 255 and still meets min_points
                make_loop($urandom_range(0, 4095), $urandom_range(0, 4095), 70,
                          $urandom_range(1, 50), 0);
                flush_path();
            end
            while (points_sent - phase_start < PHASE_POINTS)
                random_stroke();
        end
        i_s_axis_tvalid <= 1'b0;

        wait_idle(DRAIN_CYCLES);
        if (tracker.verdict_q.size() != 0) begin
            $error("%0d stroke results never arrived", tracker.verdict_q.size());
            tracker.mismatches++;
        end

        $display("Sent %0d points in %0d strokes across %0d settings (%0d config words).",
                 points_sent, strokes_sent, NUM_PHASES + 1, cfg_words);
        $display("Checked %0d result words, %0d reported closed.",
                 tracker.verdicts_seen, tracker.closed_seen);
        if (tracker.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
